// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge out of reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Expression must never be true out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== rtl/fqd_pkg.sv =====
package fqd_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int ITEM_WIDTH_DEF = 32;

	// command codes
	typedef enum logic [1:0] {
		CMD_ENQ = 2'd0,
		CMD_DEQ = 2'd1,
		CMD_DEL = 2'd2
	} cmd_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// controller states, one-hot
	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_DEQ   = 4'b0010,
		S_SCAN  = 4'b0100,
		S_SHIFT = 4'b1000
	} state_t;

endpackage

// ===== rtl/fqd_ram.sv =====
// Simple dual-port RAM, registered read, read-before-write.
module fqd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/fifo_queue_with_value_delete.sv =====
// Channel   Handshake              Words
// --------  ---------------------  ------------------------------------------
// command   start && !busy         command, item_value
// result    strobe (one cycle)     status, read_value, is_empty, entry_count
//
// Enqueue: done at the accepting edge, which also registers the result; busy stays low.
// Dequeue: one RAM read, then the result is registered on leaving S_DEQ.
// Delete: one entry per cycle through the single RAM read port, scan up to the
//   match and then compaction to the tail.
// Reset clears pointers, count and controller; the RAM needs no clearing.
// The receiver cannot stall: each result is flagged by strobe for a single cycle.
`include "assert_macros.svh"

module fifo_queue_with_value_delete
	import fqd_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [31:0] item_value,
	output logic        strobe,
	output logic [1:0]  status,
	output logic [31:0] read_value,
	output logic        is_empty,
	output logic [4:0]  entry_count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	// bits of an item that the 32-bit port can actually carry
	localparam int VW = (ITEM_WIDTH < 32) ? ITEM_WIDTH : 32;

	function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] p);
		if (p == AW'(DEPTH - 1)) begin
			return '0;
		end
		return p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] wrap_prev(input logic [AW-1:0] p);
		if (p == '0) begin
			return AW'(DEPTH - 1);
		end
		return p - AW'(1);
	endfunction

	state_t                state_q;
	logic [AW-1:0]         head_q;
	logic [AW-1:0]         tail_q;
	logic [CW-1:0]         count_q;
	// pos_q: scan position, later the compaction destination
	// k_q:   scan index from head, later the index of the entry being moved
	logic [AW-1:0]         pos_q;
	logic [CW-1:0]         k_q;
	logic [ITEM_WIDTH-1:0] val_q;
	logic                  strobe_q;
	status_t               status_q;
	logic [31:0]           read_value_q;

	logic                  accept;
	logic                  full;
	logic [ITEM_WIDTH-1:0] in_val;
	logic [AW-1:0]         pos_next;
	logic [CW-1:0]         k_next;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [ITEM_WIDTH-1:0] ram_wdata;
	logic [AW-1:0]         ram_raddr;
	logic [ITEM_WIDTH-1:0] ram_rdata;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign full     = (count_q == CW'(DEPTH));
	assign in_val   = ITEM_WIDTH'(item_value[VW-1:0]);
	assign pos_next = wrap_next(pos_q);
	assign k_next   = k_q + CW'(1);

	// RAM port control. Scan reads one entry ahead of the compare; compaction
	// writes entry j into slot j-1 while reading entry j+1, so a slot is always
	// read before it is overwritten.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = tail_q;
		ram_wdata = in_val;
		ram_raddr = head_q;
		unique case (state_q)
			S_IDLE: begin
				ram_we = accept && (command == CMD_ENQ) && !full;
			end
			S_SCAN: begin
				ram_raddr = pos_next;
			end
			S_SHIFT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = ram_rdata;
				ram_raddr = wrap_next(pos_next);
			end
			default: begin
			end
		endcase
	end

	fqd_ram #(
		.WIDTH(ITEM_WIDTH),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (command)
							CMD_ENQ: begin
								strobe_q <= 1'b1;
								if (!full) begin
									tail_q  <= wrap_next(tail_q);
									count_q <= count_q + CW'(1);
								end
							end
							CMD_DEQ: begin
								if (count_q == '0) begin
									strobe_q <= 1'b1;
								end else begin
									state_q <= S_DEQ;
								end
							end
							CMD_DEL: begin
								if (count_q == '0) begin
									strobe_q <= 1'b1;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								strobe_q <= 1'b1;
							end
						endcase
					end
				end
				S_DEQ: begin
					head_q   <= wrap_next(head_q);
					count_q  <= count_q - CW'(1);
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_SCAN: begin
					if (ram_rdata == val_q) begin
						if (k_next == count_q) begin
							// match is the last entry: nothing to move
							tail_q   <= wrap_prev(tail_q);
							count_q  <= count_q - CW'(1);
							strobe_q <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							state_q <= S_SHIFT;
						end
					end else if (k_next == count_q) begin
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_SHIFT: begin
					if (k_next == count_q) begin
						tail_q   <= wrap_prev(tail_q);
						count_q  <= count_q - CW'(1);
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					read_value_q <= '0;
					val_q        <= in_val;
					pos_q        <= head_q;
					k_q          <= '0;
					unique case (command)
						CMD_ENQ:  status_q <= full ? ST_FULL : ST_DONE;
						default:  status_q <= ST_MISS;
					endcase
				end
			end
			S_DEQ: begin
				read_value_q <= 32'(ram_rdata[VW-1:0]);
				status_q     <= ST_DONE;
			end
			S_SCAN: begin
				if (ram_rdata == val_q) begin
					// pos_q stays as the first hole; k_q moves to the next entry
					k_q      <= k_next;
					status_q <= ST_DONE;
				end else begin
					pos_q <= pos_next;
					k_q   <= k_next;
				end
			end
			S_SHIFT: begin
				pos_q <= pos_next;
				k_q   <= k_next;
			end
			default: begin
			end
		endcase
	end

	assign strobe      = strobe_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign is_empty    = (count_q == '0);
	assign entry_count = 5'(count_q);

	`ASSERT_PROP(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH))
	`ASSERT_PROP(a_strobe_idle, clk, arst_n, strobe_q |-> (state_q == S_IDLE))
	`ASSERT_PROP(a_enq_grows, clk, arst_n, (accept && (command == CMD_ENQ) && !full) |=> (strobe_q && (count_q == $past(count_q) + CW'(1))))
	`ASSERT_NEVER(a_no_write_scan, clk, arst_n, ram_we && ((state_q == S_SCAN) || (state_q == S_DEQ)))

endmodule

// ===== bench/tb_fifo_queue_with_value_delete.sv =====
`timescale 1ns / 1ps

module tb_fifo_queue_with_value_delete;
	import fqd_pkg::*;

	localparam int QUEUE_DEPTH   = DEPTH_DEF;
	localparam int RANDOM_WORDS  = 1830;
	localparam int TAIL_WORDS    = 300;     // closing stretch runs with no gaps
	localparam int SETTLE_CYCLES = 40;      // a full delete sweep plus margin
	localparam int CYCLE_LIMIT   = 500000;
	localparam int PRINT_CAP     = 60;

	// command code 3 has no meaning in the block; it must come back as a miss
	localparam logic [1:0] CMD_SPARE = 2'd3;

	// traffic flavor of a random stretch
	typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_t;

	// one expected result word
	typedef struct packed {
		status_t     status;
		logic [31:0] read_value;
		logic        is_empty;
		logic [4:0]  entry_count;
	} fqd_result_t;

	// Shadow of the queue contents plus the list of result words still owed.
	// The shadow is kept as a plain ordered list: head at index 0, so delete
	// by value is "remove first match" and the order of the rest is kept.
	class fqd_scoreboard;
		logic [31:0] held[$];
		fqd_result_t pending[$];
		int mismatches, checked;
		int n_enq, n_full, n_deq, n_empty, n_del_hit, n_del_miss, n_spare;

		task report(string msg);
			mismatches++;
			if (mismatches <= PRINT_CAP)
				$display("[%0t] %s", $time, msg);
		endtask

		// update the shadow for one accepted command word, queue its result
		function void note_word(logic [1:0] cmd, logic [31:0] val);
			fqd_result_t r;
			int hit;
			r.status = ST_MISS;
			r.read_value = '0;
			hit = -1;
			case (cmd)
				CMD_ENQ: begin
					n_enq++;
					if (held.size() >= QUEUE_DEPTH) begin
						r.status = ST_FULL;
						n_full++;
					end else begin
						held.push_back(val);
						r.status = ST_DONE;
					end
				end
				CMD_DEQ: begin
					n_deq++;
					if (held.size() == 0) begin
						n_empty++;
					end else begin
						r.read_value = held.pop_front();
						r.status = ST_DONE;
					end
				end
				CMD_DEL: begin
					foreach (held[i])
						if (hit < 0 && held[i] == val)
							hit = i;
					if (hit >= 0) begin
						held.delete(hit);
						r.status = ST_DONE;
						n_del_hit++;
					end else begin
						n_del_miss++;
					end
				end
				default: n_spare++;
			endcase
			r.is_empty = (held.size() == 0);
			r.entry_count = 5'(held.size());
			pending.push_back(r);
		endfunction

		task check_result(logic [1:0] st, logic [31:0] rv, logic emp, logic [4:0] cnt);
			fqd_result_t x;
			if (pending.size() == 0) begin
				report($sformatf("result word with nothing owed: status=%0d count=%0d",
					st, cnt));
				return;
			end
			x = pending.pop_front();
			checked++;
			if (st !== x.status)
				report($sformatf("status %0d, want %0d", st, x.status));
			if (rv !== x.read_value)
				report($sformatf("read_value %h, want %h", rv, x.read_value));
			if (emp !== x.is_empty)
				report($sformatf("is_empty %b, want %b", emp, x.is_empty));
			if (cnt !== x.entry_count)
				report($sformatf("entry_count %0d, want %0d", cnt, x.entry_count));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  command = CMD_ENQ;
	logic [31:0] item_value = '0;
	logic        busy;
	logic        strobe;
	logic [1:0]  status;
	logic [31:0] read_value;
	logic        is_empty;
	logic [4:0]  entry_count;

	fqd_scoreboard sb = new();
	int cycle_count = 0;

	fifo_queue_with_value_delete dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.item_value  (item_value),
		.strobe      (strobe),
		.status      (status),
		.read_value  (read_value),
		.is_empty    (is_empty),
		.entry_count (entry_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: the receiver never stalls, so every strobe is a result word.
	// Outputs are read at the edge, before the block's own updates land.
	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_result(status, read_value, is_empty, entry_count);
	end

	// Hard stop in case the block hangs or loses a result.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d result words still owed",
			cycle_count, sb.pending.size());
		$display("Mismatches found");
		$finish;
	end

	// Present one command word and hold it until the block takes it.
	// start stays high when the next call follows straight away.
	task automatic send_word(logic [1:0] cmd, logic [31:0] val);
		start <= 1'b1;
		command <= cmd;
		item_value <= val;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		sb.note_word(cmd, val);
	endtask

	// sender gap
	task automatic pause(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// item values: mostly full 32-bit random, some from a tiny pool so that
	// duplicates show up, some near all-ones
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1: return 32'($urandom_range(0, 7));
			2: return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
			default: return 32'($urandom);
		endcase
	endfunction

	initial begin : stimulus
		traffic_t mix;
		int mix_left;
		bit quiet;
		int roll;
		logic [1:0] cmd;
		logic [31:0] val;

		mix = MIX_EVEN;
		mix_left = 0;
		quiet = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed: empty-queue misses, spare code, extremes, middle delete
		send_word(CMD_DEQ, 32'h0);               // dequeue when empty
		send_word(CMD_DEL, 32'h0);               // delete on empty queue
		send_word(CMD_SPARE, 32'hFFFF_FFFF);     // unused code
		send_word(CMD_ENQ, 32'h0);
		send_word(CMD_ENQ, 32'hFFFF_FFFF);
		send_word(CMD_ENQ, 32'h1);
		send_word(CMD_ENQ, 32'h8000_0000);
		send_word(CMD_DEL, 32'hFFFF_FFFF);       // match in the middle, compact
		send_word(CMD_DEL, 32'h1234_5678);       // no match on non-empty queue
		send_word(CMD_DEQ, 32'hFFFF_FFFF);       // read_value should be zero item
		// fill to the brim, with a second copy of 1 further back
		for (int k = 0; k < QUEUE_DEPTH - 2; k++)
			send_word(CMD_ENQ, (k == 5) ? 32'h1 : 32'hA5A5_0000 + 32'(k));
		send_word(CMD_ENQ, 32'h7FFF_FFFF);       // enqueue when full
		send_word(CMD_DEL, 32'h1);               // first match only (head)
		send_word(CMD_DEL, 32'hA5A5_000D);       // match at the tail

		// --- random traffic in stretches biased toward filling, draining or even
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (mix_left == 0) begin
				mix = traffic_t'($urandom_range(0, 2));
				mix_left = $urandom_range(20, 90);
				quiet = ($urandom_range(0, 3) == 0);
			end
			mix_left--;
			roll = $urandom_range(0, 99);
			if (roll < 3)
				cmd = CMD_SPARE;
			else begin
				case (mix)
					MIX_FILL:  cmd = (roll < 75) ? CMD_ENQ : (roll < 88) ? CMD_DEQ : CMD_DEL;
					MIX_DRAIN: cmd = (roll < 25) ? CMD_ENQ : (roll < 60) ? CMD_DEQ : CMD_DEL;
					default:   cmd = (roll < 45) ? CMD_ENQ : (roll < 70) ? CMD_DEQ : CMD_DEL;
				endcase
			end
			// most deletes aim at a stored entry, anywhere in the queue
			if (cmd == CMD_DEL && sb.held.size() > 0 && $urandom_range(0, 3) != 0)
				val = sb.held[$urandom_range(0, sb.held.size() - 1)];
			else
				val = pick_value();
			send_word(cmd, val);
			if (i < RANDOM_WORDS - TAIL_WORDS && !quiet && $urandom_range(0, 4) == 0)
				pause($urandom_range(1, 19));
		end
		start <= 1'b0;

		// drain owed results, then give stray strobes a chance to show
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d command words: %0d enqueues (%0d while full), %0d dequeues (%0d while empty)",
			sb.n_enq + sb.n_deq + sb.n_del_hit + sb.n_del_miss + sb.n_spare,
			sb.n_enq, sb.n_full, sb.n_deq, sb.n_empty);
		$display("deletes: %0d found, %0d not found; %0d unused-code words; %0d results checked",
			sb.n_del_hit, sb.n_del_miss, sb.n_spare, sb.checked);
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== fifo_queue_with_value_delete.f =====
+incdir+rtl
rtl/fqd_pkg.sv
rtl/fqd_ram.sv
rtl/fifo_queue_with_value_delete.sv
bench/tb_fifo_queue_with_value_delete.sv
